/* sv/matrix_keypad_scanner_core_defines.svh */
// Assertion macros shared by the keypad scanner RTL.
`ifndef MATRIX_KEYPAD_SCANNER_CORE_DEFINES_SVH
`define MATRIX_KEYPAD_SCANNER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Plain property, sampled on clk_i, off during reset.
`define KPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
// Same-cycle implication.
`define KPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define KPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KPS_ASSERT(lbl, prop, msg)
`define KPS_ASSERT_IMP(lbl, ante, cons, msg)
`define KPS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/kps_pkg.sv */
// Types, constants and helpers of the keypad scanner.
package kps_pkg;

  // Geometry
  localparam int ROW_W          = 6;
  localparam int COL_W          = 3;
  localparam int CODE_W         = 8;
  localparam int CNT_W          = 8;
  localparam int KPS_COLUMNS    = 8;
  localparam int SLOTS_DEF      = 4;
  localparam int FIFO_DEPTH_DEF = 16;
  localparam int FIFO_W         = CODE_W + 1;
  localparam int CFG_IDX_W      = 2;

  // Row mask used for level sensing when a slot holds no mask
  localparam logic [ROW_W-1:0] ROW_FALLBACK = 6'h01;

  // Register reset values
  localparam logic [CNT_W-1:0] SHORT_RST   = 8'd5;
  localparam logic [CNT_W-1:0] LONG_RST    = 8'd100;
  localparam logic [CNT_W-1:0] RELEASE_RST = 8'd3;

  typedef enum logic [1:0] {
    OP_SCAN  = 2'd0,
    OP_POP   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } kps_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHORT   = 2'd0,
    CFG_LONG    = 2'd1,
    CFG_RELEASE = 2'd2
  } kps_cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DUP,
    ST_SLOT,
    ST_QUERY,
    ST_POP,
    ST_POP_WAIT,
    ST_OUT
  } kps_state_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ROW_W-1:0]  row_levels;
    logic [CODE_W-1:0] key_number;
  } kps_in_t;

  typedef struct packed {
    logic              key_valid;
    logic [CODE_W-1:0] key_code;
    logic              long_press;
    logic              key_is_held;
    logic              any_key_held;
    logic [COL_W-1:0]  column_drive;
  } kps_out_t;

  typedef struct packed {
    logic [CNT_W-1:0] short_ticks;
    logic [CNT_W-1:0] long_ticks;
    logic [CNT_W-1:0] release_ticks;
  } kps_cfg_t;

  // One tracking slot
  typedef struct packed {
    logic             free;
    logic [ROW_W-1:0] row_mask;
    logic [COL_W-1:0] column;
    logic [CNT_W-1:0] press_count;
    logic [CNT_W-1:0] release_count;
    logic             short_flag;
    logic             long_flag;
  } kps_slot_t;

  // What the slot unit reports for the slot under the sequencer
  typedef struct packed {
    kps_slot_t         rec;
    logic [ROW_W-1:0]  dup_pend;
    logic [ROW_W-1:0]  take_pend;
    logic              took;
    logic              freed;
    logic              push;
    logic [CODE_W-1:0] push_code;
    logic              push_long;
    logic              hit;
  } kps_slot_res_t;

  // Key code: column*8 plus row mask
  function automatic logic [CODE_W-1:0] kps_code(logic [COL_W-1:0] col,
                                                 logic [ROW_W-1:0] mask);
    return {2'b00, col, 3'b000} + {2'b00, mask};
  endfunction

endpackage

/* sv/kps_ram.sv */
// Generic simple dual-port RAM with registered read.
module kps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/kps_slot_unit.sv */
// Shared slot unit: duplicate check, slot take, press/release update, query match.
module kps_slot_unit import kps_pkg::*; (
  input  kps_slot_t         slot_i,
  input  kps_cfg_t          cfg_i,
  input  logic [ROW_W-1:0]  rows_i,
  input  logic [ROW_W-1:0]  pend_i,
  input  logic [COL_W-1:0]  col_i,
  input  logic [CODE_W-1:0] key_i,
  input  logic              room_i,
  output kps_slot_res_t     res_o
);

  logic [ROW_W-1:0] low;
  logic [ROW_W-1:0] dp;
  kps_slot_t        r;
  logic             took;
  logic             here;
  logic             level;
  logic             push;
  logic [CODE_W-1:0] pcode;
  logic             plong;

  // Rows already tracked at this column drop out of the pending set
  always_comb begin
    dp = pend_i;
    for (int i = 0; i < ROW_W; i++) begin
      if (slot_i.row_mask == (ROW_W'(1) << i) && slot_i.column == col_i) begin
        dp[i] = 1'b0;
      end
    end
  end

  // Take, then press and release bookkeeping on the updated slot
  always_comb begin
    low   = pend_i & (~pend_i + ROW_W'(1));
    r     = slot_i;
    took  = 1'b0;
    push  = 1'b0;
    pcode = '0;
    plong = 1'b0;
    if (slot_i.free && pend_i != '0 && room_i) begin
      took          = 1'b1;
      r.row_mask    = low;
      r.column      = col_i;
      r.press_count = '0;
      r.short_flag  = 1'b0;
      r.long_flag   = 1'b0;
      r.free        = 1'b0;
    end

    here  = (r.column == col_i);
    level = (r.row_mask == '0) ? |(rows_i & ROW_FALLBACK) : |(rows_i & r.row_mask);

    if (!r.free && here) begin
      if (level) begin
        if (!r.short_flag && !r.long_flag && r.press_count >= cfg_i.short_ticks) begin
          r.short_flag = 1'b1;
        end
        if (!r.long_flag && r.press_count >= cfg_i.long_ticks) begin
          r.long_flag  = 1'b1;
          r.short_flag = 1'b0;
        end
        if (r.press_count < cfg_i.long_ticks) begin
          r.press_count = r.press_count + CNT_W'(1);
        end
      end else begin
        r.press_count = '0;
      end
    end

    if ((r.long_flag || r.short_flag) && here) begin
      if (!level) begin
        if (r.release_count < cfg_i.release_ticks) begin
          r.release_count = r.release_count + CNT_W'(1);
        end else begin
          push          = 1'b1;
          pcode         = kps_code(r.column, r.row_mask);
          plong         = !r.short_flag;
          r.short_flag  = 1'b0;
          r.long_flag   = 1'b0;
          r.press_count = '0;
          r.free        = 1'b1;
          r.row_mask    = '0;
          r.column      = '0;
        end
      end else begin
        r.release_count = '0;
      end
    end
  end

  always_comb begin
    res_o           = '0;
    res_o.rec       = r;
    res_o.dup_pend  = dp;
    res_o.take_pend = took ? (pend_i & ~low) : pend_i;
    res_o.took      = took;
    res_o.freed     = push;
    res_o.push      = push;
    res_o.push_code = pcode;
    res_o.push_long = plong;
    res_o.hit       = (slot_i.short_flag || slot_i.long_flag) &&
                      (kps_code(slot_i.column, slot_i.row_mask) == key_i);
  end

endmodule

/* sv/matrix_keypad_scanner_core.sv */
// Keypad scanner top: sequencer, slot store, key FIFO, config and output register.
// Scan item: duplicate pass, then slot pass, one slot per cycle through the shared
//   slot unit. Query: one pass over the slots. Pop: one RAM read, none when empty.
// Other ops go straight to output. A new item is accepted only when idle again.
// Reset (async, active low): slots free, pointers, column and counters zero,
//   registers to defaults. FIFO RAM is not cleared; entries are read only once written.
`include "matrix_keypad_scanner_core_defines.svh"
module matrix_keypad_scanner_core import kps_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  kps_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output kps_out_t             out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CNT_W-1:0]     cfg_data_i
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int HELD_W = $clog2(SLOTS + 1);
  // Slot after reset: free flag set (top field), everything else clear
  localparam kps_slot_t SLOT_RST = kps_slot_t'({1'b1, {($bits(kps_slot_t) - 1){1'b0}}});

  kps_state_e        state_q, state_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [ROW_W-1:0]  pend_q, pend_d;
  logic [HELD_W-1:0] held_q, held_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  tail_q, tail_d;
  logic [PTR_W-1:0]  head_inc, tail_inc;
  kps_out_t          res_q, res_d;
  kps_out_t          out_q, out_d;
  logic              out_valid_q;
  kps_in_t           item_q;
  kps_cfg_t          cfg_q;
  kps_slot_t         slot_q [SLOTS];
  kps_slot_res_t     ures;
  logic              slot_we, ram_we, ram_re, out_load, item_load, last_idx;
  logic [FIFO_W-1:0] ram_rdata;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_ticks   <= SHORT_RST;
      cfg_q.long_ticks    <= LONG_RST;
      cfg_q.release_ticks <= RELEASE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SHORT:   cfg_q.short_ticks   <= cfg_data_i;
        CFG_LONG:    cfg_q.long_ticks    <= cfg_data_i;
        CFG_RELEASE: cfg_q.release_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Shared slot unit on the slot under the sequencer
  kps_slot_unit u_slot (
    .slot_i (slot_q[idx_q]),
    .cfg_i  (cfg_q),
    .rows_i (item_q.row_levels),
    .pend_i (pend_q),
    .col_i  (col_q),
    .key_i  (item_q.key_number),
    .room_i (held_q < HELD_W'(SLOTS)),
    .res_o  (ures)
  );

  // Key FIFO storage
  kps_ram #(
    .WIDTH (FIFO_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_q),
    .wdata_i ({ures.push_code, ures.push_long}),
    .re_i    (ram_re),
    .raddr_i (tail_q),
    .rdata_o (ram_rdata)
  );

  // Pointer wrap at the FIFO depth
  assign head_inc = (head_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
  assign tail_inc = (tail_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
  assign last_idx = (idx_q == SLOT_W'(SLOTS - 1));

  // Sequencer next state and controls
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    pend_d    = pend_q;
    held_d    = held_q;
    col_d     = col_q;
    head_d    = head_q;
    tail_d    = tail_q;
    res_d     = res_q;
    slot_we   = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    out_load  = 1'b0;
    item_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_load = 1'b1;
          idx_d     = '0;
          pend_d    = in_data_i.row_levels;
          res_d     = '0;
          case (in_data_i.operation)
            OP_SCAN:  state_d = ST_DUP;
            OP_POP:   state_d = ST_POP;
            OP_QUERY: state_d = ST_QUERY;
            default:  state_d = ST_OUT;
          endcase
        end
      end
      ST_DUP: begin
        pend_d = ures.dup_pend;
        if (last_idx) begin
          idx_d   = '0;
          state_d = ST_SLOT;
        end else begin
          idx_d = idx_q + SLOT_W'(1);
        end
      end
      ST_SLOT: begin
        slot_we = 1'b1;
        pend_d  = ures.take_pend;
        if (ures.took) begin
          held_d = held_q + HELD_W'(1);
        end else if (ures.freed && held_q != '0) begin
          held_d = held_q - HELD_W'(1);
        end
        // Full FIFO: entry written, head held, newest key lost
        if (ures.push) begin
          ram_we = 1'b1;
          if (head_inc != tail_q) begin
            head_d = head_inc;
          end
        end
        if (last_idx) begin
          col_d   = (col_q == COL_W'(KPS_COLUMNS - 1)) ? '0 : col_q + COL_W'(1);
          state_d = ST_OUT;
        end else begin
          idx_d = idx_q + SLOT_W'(1);
        end
      end
      ST_QUERY: begin
        if (ures.hit) begin
          res_d.key_is_held = 1'b1;
        end
        if (last_idx) begin
          state_d = ST_OUT;
        end else begin
          idx_d = idx_q + SLOT_W'(1);
        end
      end
      ST_POP: begin
        if (head_q != tail_q) begin
          ram_re  = 1'b1;
          tail_d  = tail_inc;
          state_d = ST_POP_WAIT;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_POP_WAIT: begin
        res_d.key_valid  = 1'b1;
        res_d.key_code   = ram_rdata[FIFO_W-1:1];
        res_d.long_press = ram_rdata[0];
        state_d          = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      pend_q  <= '0;
      held_q  <= '0;
      col_q   <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      held_q  <= held_d;
      col_q   <= col_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      res_q   <= res_d;
    end
  end

  // Slot store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SLOTS; s++) begin
        slot_q[s] <= SLOT_RST;
      end
    end else if (slot_we) begin
      slot_q[idx_q] <= ures.rec;
    end
  end

  // Captured item
  always_ff @(posedge clk_i) begin
    if (item_load) begin
      item_q <= in_data_i;
    end
  end

  // Output register; held count and column reflect state after the item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    out_d              = res_q;
    out_d.any_key_held = (held_q != '0);
    out_d.column_drive = col_q;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `KPS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")
  `KPS_ASSERT_IMP(a_take_room, state_q == ST_SLOT && ures.took, held_q < HELD_W'(SLOTS), "take with no room")
  `KPS_ASSERT_NEXT(a_pop_advances, state_q == ST_POP && head_q != tail_q, state_q == ST_POP_WAIT && tail_q != $past(tail_q), "pop did not advance")
  `KPS_ASSERT_IMP(a_key_only_on_pop, out_load && res_q.key_valid, item_q.operation == OP_POP, "key result outside pop")

endmodule
